/* design/two_class_ready_queue_scheduler_defines.svh */
// assertion macros shared by the scheduler modules
`ifndef TWO_CLASS_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define TWO_CLASS_READY_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCRQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcrq same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define TCRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcrq next-cycle check failed");

`endif

/* design/tcrq_pkg.sv */
// types and constants of the two-class ready-queue scheduler
package tcrq_pkg;

  localparam int TASK_COUNT_DEF = 16;
  localparam int TASK_ID_W      = 4;
  localparam int TASK_ID_COUNT  = 1 << TASK_ID_W;
  localparam int FUNC_W         = 2;
  localparam int CODE_W         = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_READY    = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_NONE  = 2'd0,
    CODE_MORE  = 2'd1,
    CODE_EMPTY = 2'd2
  } code_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [TASK_ID_W-1:0] task_id;
    logic                 urgent;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [CODE_W-1:0]    dispatch_code;
    logic [TASK_ID_W-1:0] dispatched_task;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic finish_pop;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_pending;
    logic out_busy;
  } dp_stat_t;

endpackage

/* design/tcrq_datapath.sv */
// queue memories, ready marks, pointers and result register
`include "two_class_ready_queue_scheduler_defines.svh"

module tcrq_datapath #(
  parameter int TASK_COUNT = tcrq_pkg::TASK_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcrq_pkg::ctl_cmd_t  cmd,
  output tcrq_pkg::dp_stat_t  stat,
  input  tcrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcrq_pkg::out_item_t out_data
);

  localparam int PTR_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CNT_W      = $clog2(TASK_COUNT + 1);
  localparam int MARK_COUNT = (TASK_COUNT < tcrq_pkg::TASK_ID_COUNT) ?
                              TASK_COUNT : tcrq_pkg::TASK_ID_COUNT;
  localparam int MARK_IDX_W = (MARK_COUNT > 1) ? $clog2(MARK_COUNT) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TASK_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TASK_COUNT);
  localparam logic [8:0]       TASK_COUNT_V = 9'(TASK_COUNT);

  logic [tcrq_pkg::TASK_ID_W-1:0] u_mem [TASK_COUNT];
  logic [tcrq_pkg::TASK_ID_W-1:0] n_mem [TASK_COUNT];
  logic [tcrq_pkg::TASK_ID_W-1:0] u_rd_r, n_rd_r;

  logic [MARK_COUNT-1:0] mark_r, mark_nxt;
  logic [PTR_W-1:0] u_head_r, u_head_nxt, u_tail_r, u_tail_nxt;
  logic [PTR_W-1:0] n_head_r, n_head_nxt, n_tail_r, n_tail_nxt;
  logic [CNT_W-1:0] u_cnt_r, u_cnt_nxt, n_cnt_r, n_cnt_nxt;
  logic sel_urgent_r, sel_urgent_nxt;
  tcrq_pkg::code_t code_r, code_nxt;
  logic out_valid_r;
  tcrq_pkg::out_item_t out_data_r, res_nxt;

  logic u_we, n_we, u_re, n_re, load;
  logic id_ok;
  logic [MARK_IDX_W-1:0] idx;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign id_ok = 9'(in_data.task_id) < TASK_COUNT_V;
  assign idx   = in_data.task_id[MARK_IDX_W-1:0];

  assign stat.pop_pending = (in_data.func == tcrq_pkg::OP_DISPATCH) &&
                            ((u_cnt_r != '0) || (n_cnt_r != '0));
  assign stat.out_busy    = out_valid_r && !out_ready;

  always_comb begin
    mark_nxt       = mark_r;
    u_head_nxt     = u_head_r;
    u_tail_nxt     = u_tail_r;
    u_cnt_nxt      = u_cnt_r;
    n_head_nxt     = n_head_r;
    n_tail_nxt     = n_tail_r;
    n_cnt_nxt      = n_cnt_r;
    sel_urgent_nxt = sel_urgent_r;
    code_nxt       = code_r;
    res_nxt        = '0;
    u_we = 1'b0;
    n_we = 1'b0;
    u_re = 1'b0;
    n_re = 1'b0;
    load = 1'b0;
    if (cmd.exec) begin
      case (tcrq_pkg::op_t'(in_data.func))
        tcrq_pkg::OP_READY: begin
          load = 1'b1;
          if (id_ok && !mark_r[idx]) begin
            if (in_data.urgent) begin
              if (u_cnt_r != CNT_FULL) begin
                u_we             = 1'b1;
                u_tail_nxt       = ptr_inc(u_tail_r);
                u_cnt_nxt        = u_cnt_r + CNT_W'(1);
                mark_nxt[idx]    = 1'b1;
                res_nxt.accepted = 1'b1;
              end
            end else begin
              if (n_cnt_r != CNT_FULL) begin
                n_we             = 1'b1;
                n_tail_nxt       = ptr_inc(n_tail_r);
                n_cnt_nxt        = n_cnt_r + CNT_W'(1);
                mark_nxt[idx]    = 1'b1;
                res_nxt.accepted = 1'b1;
              end
            end
          end
        end
        tcrq_pkg::OP_DISPATCH: begin
          if (u_cnt_r != '0) begin
            u_re           = 1'b1;
            u_head_nxt     = ptr_inc(u_head_r);
            u_cnt_nxt      = u_cnt_r - CNT_W'(1);
            sel_urgent_nxt = 1'b1;
            code_nxt = ((u_cnt_r != CNT_W'(1)) || (n_cnt_r != '0)) ?
                       tcrq_pkg::CODE_MORE : tcrq_pkg::CODE_EMPTY;
          end else if (n_cnt_r != '0) begin
            n_re           = 1'b1;
            n_head_nxt     = ptr_inc(n_head_r);
            n_cnt_nxt      = n_cnt_r - CNT_W'(1);
            sel_urgent_nxt = 1'b0;
            code_nxt = (n_cnt_r != CNT_W'(1)) ?
                       tcrq_pkg::CODE_MORE : tcrq_pkg::CODE_EMPTY;
          end else begin
            load = 1'b1;
          end
        end
        tcrq_pkg::OP_CLEAR: begin
          load = 1'b1;
          if (id_ok) begin
            mark_nxt[idx] = 1'b0;
          end
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end else if (cmd.finish_pop) begin
      load                    = 1'b1;
      res_nxt.dispatch_code   = code_r;
      res_nxt.dispatched_task = sel_urgent_r ? u_rd_r : n_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[u_tail_r] <= in_data.task_id;
    end
    if (u_re) begin
      u_rd_r <= u_mem[u_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      n_mem[n_tail_r] <= in_data.task_id;
    end
    if (n_re) begin
      n_rd_r <= n_mem[n_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r      <= '0;
      u_head_r    <= '0;
      u_tail_r    <= '0;
      u_cnt_r     <= '0;
      n_head_r    <= '0;
      n_tail_r    <= '0;
      n_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mark_r   <= mark_nxt;
      u_head_r <= u_head_nxt;
      u_tail_r <= u_tail_nxt;
      u_cnt_r  <= u_cnt_nxt;
      n_head_r <= n_head_nxt;
      n_tail_r <= n_tail_nxt;
      n_cnt_r  <= n_cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_urgent_r <= sel_urgent_nxt;
    code_r       <= code_nxt;
    if (load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TCRQ_ASSERT_SAME(a_cnt_bound, 1'b1, (u_cnt_r <= CNT_FULL) && (n_cnt_r <= CNT_FULL))
  `TCRQ_ASSERT_SAME(a_no_overwrite, load, !(out_valid_r && !out_ready))

endmodule

/* design/tcrq_ctrl.sv */
// controller state machine of the scheduler
`include "two_class_ready_queue_scheduler_defines.svh"

module tcrq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcrq_pkg::dp_stat_t stat,
  output tcrq_pkg::ctl_cmd_t cmd
);

  tcrq_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcrq_pkg::ST_IDLE: begin
        if (cmd.exec && stat.pop_pending) begin
          state_nxt = tcrq_pkg::ST_POP;
        end
      end
      tcrq_pkg::ST_POP: begin
        state_nxt = tcrq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.finish_pop = 1'b0;
    case (state_r)
      tcrq_pkg::ST_IDLE: begin
        in_ready = !stat.out_busy;
      end
      tcrq_pkg::ST_POP: begin
        cmd.finish_pop = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.exec = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcrq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TCRQ_ASSERT_NEXT(a_pop_one_cycle, state_r == tcrq_pkg::ST_POP, state_r == tcrq_pkg::ST_IDLE)
  `TCRQ_ASSERT_NEXT(a_pop_follows, cmd.exec && stat.pop_pending, state_r == tcrq_pkg::ST_POP)
  `TCRQ_ASSERT_SAME(a_no_take_in_pop, state_r == tcrq_pkg::ST_POP, !in_ready && !cmd.exec)

endmodule

/* design/two_class_ready_queue_scheduler.sv */
// top level of the two-class ready-queue scheduler
// Task-ready scheduler with an urgent and a normal FIFO of task ids, both
// TASK_COUNT deep, plus one ready mark per task (cleared by reset). A
// make-ready transfer (func 0) appends task_id to the FIFO chosen by urgent,
// unless the task is out of range, already marked, or its FIFO is full; the
// result says accepted. A dispatch transfer (func 1) pops the urgent head
// first, else the normal head, and reports the id and whether tasks still
// wait (code 1) or both FIFOs are now empty (code 2); code 0 means nothing
// was queued. Clear (func 2) drops one task's ready mark; func 3 does
// nothing. Every input transfer yields exactly one result transfer.
// Make-ready, clear, idle dispatch and func 3 write their result register
// directly on the input transfer; a dispatch that pops first fetches the
// FIFO head through the registered read port of its memory and loads the
// result in the pop state. The input side is ready in the idle state as soon
// as the result register is free or being emptied in the same cycle, so a
// popping dispatch holds off the next input until its result is loaded.

module two_class_ready_queue_scheduler #(
  parameter int TASK_COUNT = tcrq_pkg::TASK_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcrq_pkg::out_item_t out_data
);

  // command and status between the controller and the datapath
  tcrq_pkg::ctl_cmd_t cmd;
  tcrq_pkg::dp_stat_t stat;

  // controller: decides when an input transfer is taken and sequences
  // the pop state that finishes a popping dispatch
  tcrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: queue memories, pointers, counts, ready marks and the
  // result register that holds a finished result until its transfer
  tcrq_datapath #(
    .TASK_COUNT (TASK_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
